>>> design/usk_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// usk_pkg: shared definitions for the unsorted key set
// Operation codes, the sequencer state type and the result count width.
// ----------------------------------------------------------------------------
package usk_pkg;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;

    localparam int COUNT_W = 5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_SHIFT,
        ST_FINISH
    } state_t;

endpackage
`default_nettype wire

>>> design/usk_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// usk_store: key storage memory
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module usk_store #(
    parameter int DEPTH = 16,
    parameter int IDX_W = 4
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [IDX_W-1:0] wr_addr,
    input  wire logic [63:0]      wr_data,
    input  wire logic             rd_en,
    input  wire logic [IDX_W-1:0] rd_addr,
    output logic      [63:0]      rd_data
);

    logic [63:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

>>> design/usk_match.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// usk_match: double equality compare
// Compares two IEEE double bit patterns: NaN matches nothing, +0 equals -0.
// ----------------------------------------------------------------------------
module usk_match (
    input  wire logic [63:0] a,
    input  wire logic [63:0] b,
    output logic             equal
);

    logic a_nan;
    logic b_nan;
    logic both_zero;

    always_comb
    begin
        a_nan     = (a[62:52] == 11'h7FF) && (a[51:0] != 52'd0);
        b_nan     = (b[62:52] == 11'h7FF) && (b[51:0] != 52'd0);
        both_zero = (a[62:0] == 63'd0) && (b[62:0] == 63'd0);
        equal     = !a_nan && !b_nan && ((a == b) || both_zero);
    end

endmodule
`default_nettype wire

>>> design/unsorted_key_set_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// unsorted_key_set_unit: set of 64-bit double keys kept in arrival order
// Insert, remove and query over a memory of DEPTH keys, one entry per cycle.
// ----------------------------------------------------------------------------
//  Channel | Handshake            | Payload
//  --------+----------------------+---------------------------------------
//  input   | in_valid / in_ready  | cmd, key
//  output  | out_valid / out_ready| was_present, dropped_full, entry_count
//
//  A scan reads the stored keys in order and ends early on a hit. A remove
//  that hits then moves each later entry down by one to close the gap. An
//  empty set skips the scan. Scan and shift both read through the single
//  read port of the key memory.
//  Reset clears the count and the handshake state; the memory needs no clear.
//  in_ready is high only while the sequencer is idle. A finished result waits
//  in the output register, and the next operation may start meanwhile.
// ----------------------------------------------------------------------------
module unsorted_key_set_unit #(
    parameter int DEPTH = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  cmd,
    input  wire logic [63:0] key,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             was_present,
    output logic             dropped_full,
    output logic [usk_pkg::COUNT_W-1:0] entry_count
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int EXT_W = (CNT_W > usk_pkg::COUNT_W) ? CNT_W : usk_pkg::COUNT_W;

    usk_pkg::state_t state_reg, state_next;

    logic [1:0]       cmd_reg, cmd_next;
    logic [63:0]      key_reg, key_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] rd_idx_reg, rd_idx_next;
    logic             cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0] cmp_idx_reg, cmp_idx_next;
    logic [IDX_W-1:0] pos_reg, pos_next;
    logic             found_reg, found_next;
    logic             dropped_reg, dropped_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_present_reg, out_present_next;
    logic             out_dropped_reg, out_dropped_next;
    logic [usk_pkg::COUNT_W-1:0] out_count_reg, out_count_next;

    logic             mem_wr_en;
    logic [IDX_W-1:0] mem_wr_addr;
    logic [63:0]      mem_wr_data;
    logic             mem_rd_en;
    logic [IDX_W-1:0] mem_rd_addr;
    logic [63:0]      mem_rd_data;
    logic             key_equal;
    logic             issue;
    logic [EXT_W-1:0] count_ext;

    usk_store #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    usk_match u_match (
        .a     (mem_rd_data),
        .b     (key_reg),
        .equal (key_equal)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= usk_pkg::ST_IDLE;
            count_reg     <= '0;
            cmp_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cmp_vld_reg   <= cmp_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg         <= cmd_next;
        key_reg         <= key_next;
        rd_idx_reg      <= rd_idx_next;
        cmp_idx_reg     <= cmp_idx_next;
        pos_reg         <= pos_next;
        found_reg       <= found_next;
        dropped_reg     <= dropped_next;
        out_present_reg <= out_present_next;
        out_dropped_reg <= out_dropped_next;
        out_count_reg   <= out_count_next;
    end

    always_comb
    begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        key_next         = key_reg;
        count_next       = count_reg;
        rd_idx_next      = rd_idx_reg;
        cmp_vld_next     = 1'b0;
        cmp_idx_next     = cmp_idx_reg;
        pos_next         = pos_reg;
        found_next       = found_reg;
        dropped_next     = dropped_reg;
        out_valid_next   = out_valid_reg;
        out_present_next = out_present_reg;
        out_dropped_next = out_dropped_reg;
        out_count_next   = out_count_reg;
        in_ready         = 1'b0;
        mem_wr_en        = 1'b0;
        mem_wr_addr      = count_reg[IDX_W-1:0];
        mem_wr_data      = key_reg;
        mem_rd_en        = 1'b0;
        mem_rd_addr      = rd_idx_reg[IDX_W-1:0];
        issue            = rd_idx_reg < count_reg;
        count_ext        = EXT_W'(count_reg);

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            usk_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd_next     = cmd;
                    key_next     = key;
                    rd_idx_next  = '0;
                    found_next   = 1'b0;
                    dropped_next = 1'b0;
                    state_next   = (count_reg == '0) ? usk_pkg::ST_DECIDE : usk_pkg::ST_SCAN;
                end
            end

            usk_pkg::ST_SCAN:
            begin
                // Reads run one entry ahead of the compare on the registered data.
                mem_rd_en    = issue;
                cmp_vld_next = issue;
                cmp_idx_next = rd_idx_reg[IDX_W-1:0];
                if (issue)
                begin
                    rd_idx_next = rd_idx_reg + CNT_W'(1);
                end
                if (cmp_vld_reg && key_equal)
                begin
                    found_next   = 1'b1;
                    pos_next     = cmp_idx_reg;
                    cmp_vld_next = 1'b0;
                    state_next   = usk_pkg::ST_DECIDE;
                end
                else if (cmp_vld_reg && (CNT_W'(cmp_idx_reg) + CNT_W'(1) == count_reg))
                begin
                    cmp_vld_next = 1'b0;
                    state_next   = usk_pkg::ST_DECIDE;
                end
            end

            usk_pkg::ST_DECIDE:
            begin
                state_next = usk_pkg::ST_FINISH;
                if (cmd_reg == usk_pkg::CMD_INSERT)
                begin
                    if (!found_reg)
                    begin
                        if (count_reg < CNT_W'(DEPTH))
                        begin
                            mem_wr_en  = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                        end
                        else
                        begin
                            dropped_next = 1'b1;
                        end
                    end
                end
                else if ((cmd_reg == usk_pkg::CMD_REMOVE) && found_reg)
                begin
                    rd_idx_next = CNT_W'(pos_reg) + CNT_W'(1);
                    state_next  = usk_pkg::ST_SHIFT;
                end
            end

            usk_pkg::ST_SHIFT:
            begin
                // Each entry read at index i is written back at index i - 1.
                mem_rd_en    = issue;
                cmp_vld_next = issue;
                cmp_idx_next = rd_idx_reg[IDX_W-1:0];
                if (issue)
                begin
                    rd_idx_next = rd_idx_reg + CNT_W'(1);
                end
                if (cmp_vld_reg)
                begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = cmp_idx_reg - IDX_W'(1);
                    mem_wr_data = mem_rd_data;
                end
                else if (!issue)
                begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = usk_pkg::ST_FINISH;
                end
            end

            usk_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next   = 1'b1;
                    out_present_next = found_reg;
                    out_dropped_next = dropped_reg;
                    out_count_next   = count_ext[usk_pkg::COUNT_W-1:0];
                    state_next       = usk_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = usk_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid    = out_valid_reg;
    assign was_present  = out_present_reg;
    assign dropped_full = out_dropped_reg;
    assign entry_count  = out_count_reg;

endmodule
`default_nettype wire
